FILE: sv/gahq_pkg.sv
// Shared types and constants of the graph adjacency hop query block.
`timescale 1ns / 1ps
package gahq_pkg;

    localparam int VMAX = 32;
    localparam int VW   = $clog2(VMAX);

    typedef logic [VMAX-1:0] t_row;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_REM  = 3'd1,
        OP_TEST = 3'd2,
        OP_HOP  = 3'd3,
        OP_CNT  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROWA,
        S_ROWB,
        S_CNT,
        S_LVL,
        S_LVL_END,
        S_EMIT,
        S_FIN
    } t_state;

    // Row store access from the sequencer
    typedef struct packed {
        logic [VW-1:0] rd_addr;
        logic          we;
        logic [VW-1:0] wr_addr;
        t_row          wr_data;
    } t_ram_req;

endpackage

FILE: sv/gahq_row_ram.sv
// Adjacency row store with per-row valid bits that reset clears.
`timescale 1ns / 1ps
module gahq_row_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gahq_pkg::t_ram_req i_req,
    output gahq_pkg::t_row    o_rd_data
);
    import gahq_pkg::*;

    t_row             r_mem [VMAX];
    logic [VMAX-1:0]  r_vld;
    t_row             r_rd_data;

    // Track written rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    // Write port and registered read; unwritten rows read as zero
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_vld[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/graph_adjacency_hop_query.sv
// Top level: edge operations, neighbor count and breadth-first hop query.
// Edge add/remove update the row of a, then mirror into the row of b (read only when
// nothing changes); edge test reads a row; neighbor count is a bit scan. A hop query
// reads all rows per level, closes it, emits; absent/isolated sources stop early.
// busy is high while an item runs; results come at most one per cycle, no stalls.
// Synchronous active-low reset clears the graph and the vertex count.
`timescale 1ns / 1ps
module graph_adjacency_hop_query (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_op,
    input  logic [4:0] i_vertex_a,
    input  logic [4:0] i_vertex_b,
    input  logic [4:0] i_hop_limit,
    output logic       o_valid,
    output logic       o_found,
    output logic [4:0] o_vertex,
    output logic [4:0] o_distance,
    output logic [5:0] o_neighbor_count,
    output logic       o_last
);
    import gahq_pkg::*;

    localparam logic [VW-1:0] IDX_END = VW'(VMAX - 1);

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [VW-1:0] r_a, n_a, r_b, n_b, r_lim, n_lim;
    logic [VW:0]   r_vc, n_vc;
    logic [VW-1:0] r_idx, n_idx;
    logic [VW:0]   r_dist, n_dist;
    t_row          r_vis, n_vis, r_front, n_front, r_acc, n_acc;
    logic          r_pend, n_pend;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_hv, n_hv;
    logic [VW-1:0] r_pv, n_pv, r_pd, n_pd;
    logic          r_ov, n_ov, r_of, n_of, r_ol, n_ol;
    logic [4:0]    r_overt, n_overt, r_odist, n_odist;
    logic [5:0]    r_ocnt, n_ocnt;

    t_ram_req      ram_req;
    t_row          rd_data;
    logic          pa, pb, had;
    t_row          lvl_next;

    gahq_row_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    assign pa       = {1'b0, r_a} < r_vc;
    assign pb       = {1'b0, r_b} < r_vc;
    assign had      = pa && pb && rd_data[r_b];
    assign lvl_next = (r_acc | (r_pend ? rd_data : '0)) & ~r_vis;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vc    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vc    <= n_vc;
            r_ov    <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_lim   <= n_lim;
        r_idx   <= n_idx;
        r_dist  <= n_dist;
        r_vis   <= n_vis;
        r_front <= n_front;
        r_acc   <= n_acc;
        r_pend  <= n_pend;
        r_cnt   <= n_cnt;
        r_hv    <= n_hv;
        r_pv    <= n_pv;
        r_pd    <= n_pd;
        r_of    <= n_of;
        r_ol    <= n_ol;
        r_overt <= n_overt;
        r_odist <= n_odist;
        r_ocnt  <= n_ocnt;
    end

    // Sequencer: next state, row store access and result transfer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_lim   = r_lim;
        n_vc    = r_vc;
        n_idx   = r_idx;
        n_dist  = r_dist;
        n_vis   = r_vis;
        n_front = r_front;
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_hv    = r_hv;
        n_pv    = r_pv;
        n_pd    = r_pd;
        n_ov    = 1'b0;
        n_of    = 1'b0;
        n_ol    = 1'b1;
        n_overt = '0;
        n_odist = '0;
        n_ocnt  = '0;
        ram_req.rd_addr = r_a;
        ram_req.we      = 1'b0;
        ram_req.wr_addr = r_a;
        ram_req.wr_data = rd_data;

        unique case (r_state)
            S_IDLE: begin
                ram_req.rd_addr = i_vertex_a;
                if (start) begin
                    n_op    = t_op'(i_op);
                    n_a     = i_vertex_a;
                    n_b     = i_vertex_b;
                    n_lim   = i_hop_limit;
                    n_state = S_ROWA;
                end
            end
            S_ROWA: begin
                ram_req.rd_addr = r_b;
                unique case (r_op)
                    OP_ADD: begin
                        if (had) begin
                            n_ov    = 1'b1;
                            n_of    = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            ram_req.we      = 1'b1;
                            ram_req.wr_data = rd_data | (t_row'(1) << r_b);
                            if ({1'b0, r_a} >= n_vc) n_vc = {1'b0, r_a} + 1'b1;
                            if ({1'b0, r_b} >= n_vc) n_vc = {1'b0, r_b} + 1'b1;
                            n_state = S_ROWB;
                        end
                    end
                    OP_REM: begin
                        if (had) begin
                            ram_req.we      = 1'b1;
                            ram_req.wr_data = rd_data & ~(t_row'(1) << r_b);
                            n_state         = S_ROWB;
                        end else begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    OP_TEST: begin
                        n_ov    = 1'b1;
                        n_of    = had;
                        n_state = S_IDLE;
                    end
                    OP_CNT: begin
                        if (pa) begin
                            n_acc   = rd_data;
                            n_cnt   = {5'd0, rd_data[r_a]};
                            n_idx   = '0;
                            n_state = S_CNT;
                        end else begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    OP_HOP: begin
                        if (!pa || rd_data == '0) begin
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_vis   = t_row'(1) << r_a;
                            n_front = t_row'(1) << r_a;
                            n_dist  = (VW+1)'(1);
                            n_hv    = 1'b0;
                            n_idx   = '0;
                            n_acc   = '0;
                            n_pend  = 1'b0;
                            n_state = (r_lim == '0) ? S_FIN : S_LVL;
                        end
                    end
                    default: begin
                        n_ov    = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ROWB: begin
                // Mirror the change into the other endpoint's row
                ram_req.we      = 1'b1;
                ram_req.wr_addr = r_b;
                ram_req.wr_data = (r_op == OP_ADD) ? (rd_data | (t_row'(1) << r_a))
                                                   : (rd_data & ~(t_row'(1) << r_a));
                n_ov    = 1'b1;
                n_of    = (r_op == OP_REM);
                n_state = S_IDLE;
            end
            S_CNT: begin
                n_cnt = r_cnt + {5'd0, r_acc[r_idx]};
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_END) begin
                    n_ov    = 1'b1;
                    n_ocnt  = n_cnt;
                    n_state = S_IDLE;
                end
            end
            S_LVL: begin
                // Read every row, OR in those on the frontier
                ram_req.rd_addr = r_idx;
                n_pend = r_front[r_idx];
                if (r_pend) n_acc = r_acc | rd_data;
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_END) n_state = S_LVL_END;
            end
            S_LVL_END: begin
                n_front = lvl_next;
                n_vis   = r_vis | lvl_next;
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Hold one result back so the final one can carry last
                if (r_front[r_idx]) begin
                    if (r_hv) begin
                        n_ov    = 1'b1;
                        n_of    = 1'b1;
                        n_ol    = 1'b0;
                        n_overt = r_pv;
                        n_odist = r_pd;
                    end
                    n_hv = 1'b1;
                    n_pv = r_idx;
                    n_pd = r_dist[VW-1:0];
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_END) begin
                    if (r_front != '0 && r_dist < {1'b0, r_lim}) begin
                        n_dist  = r_dist + 1'b1;
                        n_acc   = '0;
                        n_pend  = 1'b0;
                        n_state = S_LVL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_ov    = 1'b1;
                n_of    = r_hv;
                n_overt = r_hv ? r_pv : '0;
                n_odist = r_hv ? r_pd : '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_ov;
    assign o_found          = r_of;
    assign o_vertex         = r_overt;
    assign o_distance       = r_odist;
    assign o_neighbor_count = r_ocnt;
    assign o_last           = r_ol;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("final result while item still running");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result after item ended");
    a_mid_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_found)
        else $error("non-final result without a vertex");
    a_vc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_vc >= $past(r_vc))
        else $error("vertex count shrank");
`endif

endmodule
